// ----- rtl/terminal_line_editor_assert.svh -----
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// same-cycle implication
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tle_pkg.sv -----
package tle_pkg;

	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_INSERT    = 3'd1;
	localparam logic [2:0] ACT_LEFT      = 3'd2;
	localparam logic [2:0] ACT_RIGHT     = 3'd3;
	localparam logic [2:0] ACT_DELETE    = 3'd4;
	localparam logic [2:0] ACT_BACKSPACE = 3'd5;
	localparam logic [2:0] ACT_DONE      = 3'd6;
	localparam logic [2:0] ACT_READ      = 3'd7;

	localparam logic [1:0] PH_NORMAL = 2'd0;
	localparam logic [1:0] PH_ESC    = 2'd1;
	localparam logic [1:0] PH_CSI    = 2'd2;

	localparam logic [7:0] CH_CTRL_A  = 8'd1;
	localparam logic [7:0] CH_CTRL_E  = 8'd5;
	localparam logic [7:0] CH_BS      = 8'd8;
	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_ESC     = 8'd27;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_DEL     = 8'd127;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_UPPER_D = 8'h44;
	localparam logic [7:0] CH_UPPER_C = 8'h43;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic [7:0] CSI_HOME   = 8'd1;
	localparam logic [7:0] CSI_DELETE = 8'd3;
	localparam logic [7:0] CSI_END    = 8'd4;
	localparam logic [7:0] CSI_MAX    = 8'd255;

	typedef struct packed {
		logic accept;
		logic shift;
		logic put;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic need_shift;
		logic ins_pend;
		logic shift_done;
	} stat_t;

endpackage

// ----- rtl/tle_ram.sv -----
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4095
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tle_ctrl.sv -----
module tle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  tle_pkg::stat_t stat,
	output tle_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SHIFT  = 2'd1;
	localparam logic [1:0] ST_PUT    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.shift  = (state_q == ST_SHIFT);
		cmd.put    = (state_q == ST_PUT);
		cmd.load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.need_shift ? ST_SHIFT : ST_FINISH;
				end
			end
			ST_SHIFT: begin
				if (stat.shift_done) begin
					state_d = stat.ins_pend ? ST_PUT : ST_FINISH;
				end
			end
			ST_PUT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (cmd.load) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/tle_datapath.sv -----
module tle_datapath #(
	parameter int LINE_MAX = 4095
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tle_pkg::cmd_t  cmd,
	output tle_pkg::stat_t stat,
	input  logic           command,
	input  logic [7:0]     rx_byte,
	input  logic [11:0]    read_index,
	output logic [2:0]     action,
	output logic [7:0]     echo_char,
	output logic [11:0]    move_count,
	output logic [11:0]    line_length,
	output logic [7:0]     read_data
);

	localparam int PW = $clog2(LINE_MAX + 1);
	localparam int AW = $clog2(LINE_MAX);
	localparam int CW = (PW > 12) ? PW : 12;

	// editor state
	logic [PW-1:0] cur_q, len_q, done_q;
	logic [1:0]    phase_q;
	logic [7:0]    csi_q;

	// shift engine
	logic [AW-1:0] src_q;
	logic [PW-1:0] cnt_q;
	logic          dir_ins_q;
	logic          ins_pend_q;
	logic [AW-1:0] put_addr_q;
	logic [7:0]    put_char_q;
	logic          wr_v_s1;
	logic [AW-1:0] wr_addr_s1;

	// result staging and output
	logic [2:0]    res_act_q;
	logic [7:0]    res_echo_q;
	logic [11:0]   res_count_q;
	logic [11:0]   res_len_q;
	logic          rd_hit_q;
	logic [2:0]    action_q;
	logic [7:0]    echo_q;
	logic [11:0]   count_q;
	logic [11:0]   length_q;
	logic [7:0]    data_q;

	// decode
	logic [PW-1:0] cur_d, len_d, done_d, count_d, lenout_d, tail_d;
	logic [1:0]    phase_d;
	logic [7:0]    csi_d;
	logic [2:0]    act_d;
	logic [7:0]    echo_d;
	logic [AW-1:0] src_d;
	logic          ins_d, del_d, hit_d, shift_d;
	logic [CW-1:0] idx_ext;
	logic [11:0]   csi_next;

	// memory port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	assign idx_ext  = CW'(read_index);
	assign csi_next = (12'(csi_q) << 3) + (12'(csi_q) << 1) + 12'(rx_byte - tle_pkg::CH_ZERO);

	always_comb begin
		cur_d    = cur_q;
		len_d    = len_q;
		done_d   = done_q;
		phase_d  = phase_q;
		csi_d    = csi_q;
		act_d    = tle_pkg::ACT_NONE;
		echo_d   = '0;
		count_d  = '0;
		lenout_d = '0;
		tail_d   = '0;
		src_d    = '0;
		ins_d    = 1'b0;
		del_d    = 1'b0;
		hit_d    = 1'b0;
		if (command) begin
			act_d = tle_pkg::ACT_READ;
			hit_d = idx_ext < CW'(done_q);
		end else begin
			unique case (phase_q)
				tle_pkg::PH_ESC: begin
					if (rx_byte == tle_pkg::CH_LBRACK) begin
						phase_d = tle_pkg::PH_CSI;
						csi_d   = '0;
					end else begin
						phase_d = tle_pkg::PH_NORMAL;
					end
				end
				tle_pkg::PH_CSI: begin
					if (rx_byte >= tle_pkg::CH_ZERO && rx_byte <= tle_pkg::CH_NINE) begin
						csi_d = (csi_next > 12'(tle_pkg::CSI_MAX)) ? tle_pkg::CSI_MAX
							: csi_next[7:0];
					end else begin
						phase_d = tle_pkg::PH_NORMAL;
						priority if (rx_byte == tle_pkg::CH_UPPER_D) begin
							if (cur_q != '0) begin
								cur_d   = cur_q - 1'b1;
								act_d   = tle_pkg::ACT_LEFT;
								count_d = PW'(1);
							end
						end else if (rx_byte == tle_pkg::CH_UPPER_C) begin
							if (cur_q < len_q) begin
								cur_d   = cur_q + 1'b1;
								act_d   = tle_pkg::ACT_RIGHT;
								count_d = PW'(1);
							end
						end else if (rx_byte == tle_pkg::CH_TILDE) begin
							priority if (csi_q == tle_pkg::CSI_HOME) begin
								count_d = cur_q;
								cur_d   = '0;
								act_d   = (cur_q != '0) ? tle_pkg::ACT_LEFT : tle_pkg::ACT_NONE;
							end else if (csi_q == tle_pkg::CSI_DELETE) begin
								if (cur_q < len_q) begin
									del_d  = 1'b1;
									tail_d = len_q - cur_q - 1'b1;
									src_d  = AW'(cur_q + 1'b1);
									len_d  = len_q - 1'b1;
									act_d  = tle_pkg::ACT_DELETE;
								end
							end else if (csi_q == tle_pkg::CSI_END) begin
								count_d = len_q - cur_q;
								cur_d   = len_q;
								act_d   = (len_q != cur_q) ? tle_pkg::ACT_RIGHT
									: tle_pkg::ACT_NONE;
							end else begin
								act_d = tle_pkg::ACT_NONE;
							end
						end else begin
							act_d = tle_pkg::ACT_NONE;
						end
					end
				end
				default: begin
					phase_d = tle_pkg::PH_NORMAL;
					priority if (rx_byte == tle_pkg::CH_CTRL_A) begin
						count_d = cur_q;
						cur_d   = '0;
						act_d   = (cur_q != '0) ? tle_pkg::ACT_LEFT : tle_pkg::ACT_NONE;
					end else if (rx_byte == tle_pkg::CH_CTRL_E) begin
						count_d = len_q - cur_q;
						cur_d   = len_q;
						act_d   = (len_q != cur_q) ? tle_pkg::ACT_RIGHT : tle_pkg::ACT_NONE;
					end else if (rx_byte == tle_pkg::CH_LF || rx_byte == tle_pkg::CH_CR) begin
						act_d    = tle_pkg::ACT_DONE;
						lenout_d = len_q;
						done_d   = len_q;
						cur_d    = '0;
						len_d    = '0;
					end else if (rx_byte == tle_pkg::CH_ESC) begin
						phase_d = tle_pkg::PH_ESC;
					end else if (rx_byte == tle_pkg::CH_BS || rx_byte == tle_pkg::CH_DEL) begin
						if (cur_q != '0) begin
							del_d  = 1'b1;
							tail_d = len_q - cur_q;
							src_d  = AW'(cur_q);
							cur_d  = cur_q - 1'b1;
							len_d  = len_q - 1'b1;
							act_d  = tle_pkg::ACT_BACKSPACE;
						end
					end else if (rx_byte >= tle_pkg::CH_SPACE) begin
						if (len_q < PW'(LINE_MAX)) begin
							ins_d  = 1'b1;
							tail_d = len_q - cur_q;
							src_d  = AW'(len_q - 1'b1);
							len_d  = len_q + 1'b1;
							cur_d  = cur_q + 1'b1;
							act_d  = tle_pkg::ACT_INSERT;
							echo_d = rx_byte;
						end
					end else begin
						act_d = tle_pkg::ACT_NONE;
					end
				end
			endcase
		end
	end

	assign shift_d = (ins_d || del_d) && (tail_d != '0);

	always_comb begin
		stat.need_shift = shift_d;
		stat.ins_pend   = ins_pend_q;
		stat.shift_done = (cnt_q == '0) && !wr_v_s1;
	end

	// one write port: shift stage, deferred insert, or direct insert at the end of line
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(cur_q);
		ram_wdata = rx_byte;
		priority if (wr_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.put) begin
			ram_we    = 1'b1;
			ram_waddr = put_addr_q;
			ram_wdata = put_char_q;
		end else if (cmd.accept && ins_d && tail_d == '0) begin
			ram_we = 1'b1;
		end else begin
			ram_we = 1'b0;
		end
	end

	assign ram_re    = (cmd.accept && hit_d) || (cmd.shift && cnt_q != '0);
	assign ram_raddr = cmd.shift ? src_q : idx_ext[AW-1:0];

	tle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_MAX)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			len_q      <= '0;
			done_q     <= '0;
			phase_q    <= tle_pkg::PH_NORMAL;
			csi_q      <= '0;
			cnt_q      <= '0;
			ins_pend_q <= 1'b0;
			wr_v_s1    <= 1'b0;
		end else begin
			wr_v_s1 <= cmd.shift && (cnt_q != '0);
			if (cmd.accept) begin
				cur_q      <= cur_d;
				len_q      <= len_d;
				done_q     <= done_d;
				phase_q    <= phase_d;
				csi_q      <= csi_d;
				cnt_q      <= shift_d ? tail_d : '0;
				ins_pend_q <= shift_d && ins_d;
			end else if (cmd.shift && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			src_q       <= src_d;
			dir_ins_q   <= ins_d;
			put_addr_q  <= AW'(cur_q);
			put_char_q  <= rx_byte;
			res_act_q   <= act_d;
			res_echo_q  <= echo_d;
			res_count_q <= 12'(count_d);
			res_len_q   <= 12'(lenout_d);
			rd_hit_q    <= hit_d;
		end else if (cmd.shift && cnt_q != '0) begin
			src_q <= dir_ins_q ? src_q - 1'b1 : src_q + 1'b1;
		end
		if (cmd.shift) begin
			wr_addr_s1 <= dir_ins_q ? src_q + 1'b1 : src_q - 1'b1;
		end
		if (cmd.load) begin
			action_q <= res_act_q;
			echo_q   <= res_echo_q;
			count_q  <= res_count_q;
			length_q <= res_len_q;
			data_q   <= rd_hit_q ? ram_rdata : 8'd0;
		end
	end

	assign action      = action_q;
	assign echo_char   = echo_q;
	assign move_count  = count_q;
	assign line_length = length_q;
	assign read_data   = data_q;

endmodule

// ----- rtl/terminal_line_editor.sv -----
// Flow: an item that moves no stored bytes goes from accept to the finish state, which
//   loads the output register; an insert or delete that moves stored bytes first passes
//   the shift state, and an insert then the put state that writes its byte. A new item is
//   taken only once the last is loaded; the line RAM moves one byte per cycle while
//   shifting; a full output register holds the finished item until the result is taken.
// Reset (arst_n low): cursor, length, escape state, CSI number and completed length clear;
//   line RAM contents are not cleared, no clearing pass is needed.
module terminal_line_editor #(
	parameter int LINE_MAX = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	input  logic [11:0] read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [7:0]  echo_char,
	output logic [11:0] move_count,
	output logic [11:0] line_length,
	output logic [7:0]  read_data
);

	tle_pkg::cmd_t  cmd;
	tle_pkg::stat_t stat;

	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tle_datapath #(
		.LINE_MAX(LINE_MAX)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.command    (command),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.action     (action),
		.echo_char  (echo_char),
		.move_count (move_count),
		.line_length(line_length),
		.read_data  (read_data)
	);

`include "terminal_line_editor_assert.svh"

	`TLE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`TLE_ASSERT_NEXT(a_load_valid, cmd.load, out_valid, "loaded result not presented")
	`TLE_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.accept, cmd.shift, cmd.put, cmd.load}), "commands overlap")

endmodule
